FILE: hw/rtl/unf_pkg.sv
// ----------------------------------------------------------------------------
// unf_pkg
// Types, constants and accent table lookups shared by the normalizer.
// ----------------------------------------------------------------------------
package unf_pkg;

  localparam int unsigned PT_W = 21;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_NFC  = 2'd1;
  localparam logic [1:0] MODE_NFD  = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [PT_W-1:0] S_BASE  = 21'h00ac00;
  localparam logic [PT_W-1:0] S_LAST  = 21'h00d7a3;
  localparam logic [PT_W-1:0] L_BASE  = 21'h001100;
  localparam logic [PT_W-1:0] L_LAST  = 21'h001112;
  localparam logic [PT_W-1:0] V_BASE  = 21'h001161;
  localparam logic [PT_W-1:0] V_LAST  = 21'h001175;
  localparam logic [PT_W-1:0] T_BASE  = 21'h0011a7;
  localparam logic [PT_W-1:0] T_FIRST = 21'h0011a8;
  localparam logic [PT_W-1:0] T_LAST  = 21'h0011c2;
  localparam logic [PT_W-1:0] N_COUNT = 21'd588;
  localparam logic [PT_W-1:0] T_COUNT = 21'd28;

  // Reciprocals for the syllable index (index below 11172)
  localparam logic [13:0] RECIP_T = 14'd9363;   // /28  as *9363 >> 18
  localparam logic [13:0] RECIP_N = 14'd14267;  // /588 as *14267 >> 23

  localparam int unsigned ACCENT_ROWS = 157;

  typedef struct packed {
    logic [8:0] whole;
    logic [7:0] letter;
    logic [9:0] accent;
  } accent_row_t;

  typedef struct packed {
    logic            valid;
    logic            lv;     // pending point is an LV syllable
    logic [PT_W-1:0] point;
  } held_t;

  typedef struct packed {
    logic [1:0]           cnt;
    logic [2:0][PT_W-1:0] pt;
    logic [2:0]           last;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [8:0] whole;
  } comp_hit_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] letter;
    logic [9:0] accent;
  } decomp_hit_t;

  localparam accent_row_t ACCENT_TAB [ACCENT_ROWS] = '{
    '{9'h0c0,"A",10'h300}, '{9'h0c1,"A",10'h301}, '{9'h0c2,"A",10'h302},
    '{9'h0c3,"A",10'h303}, '{9'h0c4,"A",10'h308}, '{9'h0c5,"A",10'h30a},
    '{9'h0c7,"C",10'h327}, '{9'h0c8,"E",10'h300}, '{9'h0c9,"E",10'h301},
    '{9'h0ca,"E",10'h302}, '{9'h0cb,"E",10'h308}, '{9'h0cc,"I",10'h300},
    '{9'h0cd,"I",10'h301}, '{9'h0ce,"I",10'h302}, '{9'h0cf,"I",10'h308},
    '{9'h0d1,"N",10'h303}, '{9'h0d2,"O",10'h300}, '{9'h0d3,"O",10'h301},
    '{9'h0d4,"O",10'h302}, '{9'h0d5,"O",10'h303}, '{9'h0d6,"O",10'h308},
    '{9'h0d9,"U",10'h300}, '{9'h0da,"U",10'h301}, '{9'h0db,"U",10'h302},
    '{9'h0dc,"U",10'h308}, '{9'h0dd,"Y",10'h301}, '{9'h0e0,"a",10'h300},
    '{9'h0e1,"a",10'h301}, '{9'h0e2,"a",10'h302}, '{9'h0e3,"a",10'h303},
    '{9'h0e4,"a",10'h308}, '{9'h0e5,"a",10'h30a}, '{9'h0e7,"c",10'h327},
    '{9'h0e8,"e",10'h300}, '{9'h0e9,"e",10'h301}, '{9'h0ea,"e",10'h302},
    '{9'h0eb,"e",10'h308}, '{9'h0ec,"i",10'h300}, '{9'h0ed,"i",10'h301},
    '{9'h0ee,"i",10'h302}, '{9'h0ef,"i",10'h308}, '{9'h0f1,"n",10'h303},
    '{9'h0f2,"o",10'h300}, '{9'h0f3,"o",10'h301}, '{9'h0f4,"o",10'h302},
    '{9'h0f5,"o",10'h303}, '{9'h0f6,"o",10'h308}, '{9'h0f9,"u",10'h300},
    '{9'h0fa,"u",10'h301}, '{9'h0fb,"u",10'h302}, '{9'h0fc,"u",10'h308},
    '{9'h0fd,"y",10'h301}, '{9'h0ff,"y",10'h308}, '{9'h100,"A",10'h304},
    '{9'h101,"a",10'h304}, '{9'h102,"A",10'h306}, '{9'h103,"a",10'h306},
    '{9'h104,"A",10'h328}, '{9'h105,"a",10'h328}, '{9'h106,"C",10'h301},
    '{9'h107,"c",10'h301}, '{9'h108,"C",10'h302}, '{9'h109,"c",10'h302},
    '{9'h10a,"C",10'h307}, '{9'h10b,"c",10'h307}, '{9'h10c,"C",10'h30c},
    '{9'h10d,"c",10'h30c}, '{9'h10e,"D",10'h30c}, '{9'h10f,"d",10'h30c},
    '{9'h112,"E",10'h304}, '{9'h113,"e",10'h304}, '{9'h114,"E",10'h306},
    '{9'h115,"e",10'h306}, '{9'h116,"E",10'h307}, '{9'h117,"e",10'h307},
    '{9'h118,"E",10'h328}, '{9'h119,"e",10'h328}, '{9'h11a,"E",10'h30c},
    '{9'h11b,"e",10'h30c}, '{9'h11c,"G",10'h302}, '{9'h11d,"g",10'h302},
    '{9'h11e,"G",10'h306}, '{9'h11f,"g",10'h306}, '{9'h120,"G",10'h307},
    '{9'h121,"g",10'h307}, '{9'h122,"G",10'h327}, '{9'h123,"g",10'h327},
    '{9'h124,"H",10'h302}, '{9'h125,"h",10'h302}, '{9'h128,"I",10'h303},
    '{9'h129,"i",10'h303}, '{9'h12a,"I",10'h304}, '{9'h12b,"i",10'h304},
    '{9'h12c,"I",10'h306}, '{9'h12d,"i",10'h306}, '{9'h12e,"I",10'h328},
    '{9'h12f,"i",10'h328}, '{9'h130,"I",10'h307}, '{9'h134,"J",10'h302},
    '{9'h135,"j",10'h302}, '{9'h139,"L",10'h301}, '{9'h13a,"l",10'h301},
    '{9'h13d,"L",10'h30c}, '{9'h13e,"l",10'h30c}, '{9'h143,"N",10'h301},
    '{9'h144,"n",10'h301}, '{9'h145,"N",10'h327}, '{9'h146,"n",10'h327},
    '{9'h147,"N",10'h30c}, '{9'h148,"n",10'h30c}, '{9'h14c,"O",10'h304},
    '{9'h14d,"o",10'h304}, '{9'h14e,"O",10'h306}, '{9'h14f,"o",10'h306},
    '{9'h150,"O",10'h30b}, '{9'h151,"o",10'h30b}, '{9'h154,"R",10'h301},
    '{9'h155,"r",10'h301}, '{9'h156,"R",10'h327}, '{9'h157,"r",10'h327},
    '{9'h158,"R",10'h30c}, '{9'h159,"r",10'h30c}, '{9'h15a,"S",10'h301},
    '{9'h15b,"s",10'h301}, '{9'h15c,"S",10'h302}, '{9'h15d,"s",10'h302},
    '{9'h15e,"S",10'h327}, '{9'h15f,"s",10'h327}, '{9'h160,"S",10'h30c},
    '{9'h161,"s",10'h30c}, '{9'h162,"T",10'h327}, '{9'h163,"t",10'h327},
    '{9'h164,"T",10'h30c}, '{9'h165,"t",10'h30c}, '{9'h168,"U",10'h303},
    '{9'h169,"u",10'h303}, '{9'h16a,"U",10'h304}, '{9'h16b,"u",10'h304},
    '{9'h16c,"U",10'h306}, '{9'h16d,"u",10'h306}, '{9'h16e,"U",10'h30a},
    '{9'h16f,"u",10'h30a}, '{9'h170,"U",10'h30b}, '{9'h171,"u",10'h30b},
    '{9'h172,"U",10'h328}, '{9'h173,"u",10'h328}, '{9'h174,"W",10'h302},
    '{9'h175,"w",10'h302}, '{9'h176,"Y",10'h302}, '{9'h177,"y",10'h302},
    '{9'h178,"Y",10'h308}, '{9'h179,"Z",10'h301}, '{9'h17a,"z",10'h301},
    '{9'h17b,"Z",10'h307}, '{9'h17c,"z",10'h307}, '{9'h17d,"Z",10'h30c},
    '{9'h17e,"z",10'h30c}
  };

  function automatic comp_hit_t accent_compose(input logic [PT_W-1:0] first,
                                               input logic [PT_W-1:0] second);
    comp_hit_t r;
    r = '0;
    for (int i = 0; i < ACCENT_ROWS; i++) begin
      if (first == {13'd0, ACCENT_TAB[i].letter} &&
          second == {11'd0, ACCENT_TAB[i].accent}) begin
        r.hit   = 1'b1;
        r.whole = ACCENT_TAB[i].whole;
      end
    end
    return r;
  endfunction

  function automatic decomp_hit_t accent_decompose(input logic [PT_W-1:0] cp);
    decomp_hit_t r;
    r = '0;
    for (int i = 0; i < ACCENT_ROWS; i++) begin
      if (cp == {12'd0, ACCENT_TAB[i].whole}) begin
        r.hit    = 1'b1;
        r.letter = ACCENT_TAB[i].letter;
        r.accent = ACCENT_TAB[i].accent;
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/unf_in_if.sv
// ----------------------------------------------------------------------------
// unf_in_if
// Code point input channel: valid/ready with point and end-of-string flag.
// ----------------------------------------------------------------------------
interface unf_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        last_in;

  modport source (output valid, output code_point, output last_in, input ready);
  modport sink   (input valid, input code_point, input last_in, output ready);
endinterface

FILE: hw/rtl/unf_out_if.sv
// ----------------------------------------------------------------------------
// unf_out_if
// Normalized point output channel: valid/ready with point and end flag.
// ----------------------------------------------------------------------------
interface unf_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] out_point;
  logic        last_out;

  modport source (output valid, output out_point, output last_out, input ready);
  modport sink   (input valid, input out_point, input last_out, output ready);
endinterface

FILE: hw/rtl/unf_decode.sv
// ----------------------------------------------------------------------------
// unf_decode
// Maps one registered code point and the pending point to up to three results.
// ----------------------------------------------------------------------------
module unf_decode (
  input  logic [1:0]       mode,
  input  logic [20:0]      cp,
  input  logic             last,
  input  unf_pkg::held_t   held,
  output unf_pkg::result_t res,
  output unf_pkg::held_t   held_upd
);

  logic                   in_hangul;
  logic [20:0]            s_wide;
  logic [13:0]            s;
  logic [27:0]            prod_t;
  logic [27:0]            prod_n;
  logic [8:0]             q_t;
  logic [4:0]             l_idx;
  logic [8:0]             v_wide;
  logic [13:0]            t_wide;
  logic [4:0]             v_idx;
  logic [4:0]             t_idx;
  logic                   cp_lv;
  logic [20:0]            hl_diff;
  logic [20:0]            cv_diff;
  logic [20:0]            ct_diff;
  logic                   lv_ok;
  logic                   lvt_ok;
  logic [20:0]            lv_pt;
  logic [20:0]            lvt_pt;
  unf_pkg::comp_hit_t     comp;
  unf_pkg::decomp_hit_t   dec;
  unf_pkg::held_t         cur;
  logic [1:0]             n;

  // Syllable index split: two independent reciprocal multiplies
  assign in_hangul = (cp >= unf_pkg::S_BASE) && (cp <= unf_pkg::S_LAST);
  assign s_wide    = cp - unf_pkg::S_BASE;
  assign s         = s_wide[13:0];
  assign prod_t    = 28'(s) * 28'(unf_pkg::RECIP_T);
  assign prod_n    = 28'(s) * 28'(unf_pkg::RECIP_N);
  assign q_t       = prod_t[26:18];
  assign l_idx     = prod_n[27:23];
  assign v_wide    = q_t - 9'(l_idx) * 9'd21;
  assign t_wide    = s - 14'(q_t) * 14'(unf_pkg::T_COUNT);
  assign v_idx     = v_wide[4:0];
  assign t_idx     = t_wide[4:0];
  assign cp_lv     = in_hangul && (t_idx == 5'd0);

  assign hl_diff = held.point - unf_pkg::L_BASE;
  assign cv_diff = cp - unf_pkg::V_BASE;
  assign ct_diff = cp - unf_pkg::T_BASE;
  assign lv_ok   = (held.point >= unf_pkg::L_BASE) && (held.point <= unf_pkg::L_LAST) &&
                   (cp >= unf_pkg::V_BASE) && (cp <= unf_pkg::V_LAST);
  assign lvt_ok  = held.lv && (cp >= unf_pkg::T_FIRST) && (cp <= unf_pkg::T_LAST);
  assign lv_pt   = unf_pkg::S_BASE + 21'(hl_diff[4:0]) * unf_pkg::N_COUNT
                 + 21'(cv_diff[4:0]) * unf_pkg::T_COUNT;
  assign lvt_pt  = held.point + 21'(ct_diff[4:0]);
  assign comp    = unf_pkg::accent_compose(held.point, cp);
  assign dec     = unf_pkg::accent_decompose(cp);

  always_comb begin
    res      = '0;
    held_upd = held;
    cur      = '0;
    n        = 2'd0;
    case (mode)
      unf_pkg::MODE_NFC: begin
        if (held.valid && (lv_ok || lvt_ok || comp.hit)) begin
          cur.valid = 1'b1;
          cur.lv    = lv_ok;
          cur.point = lv_ok ? lv_pt : (lvt_ok ? lvt_pt : 21'(comp.whole));
        end else begin
          if (held.valid) begin
            res.pt[0] = held.point;
            n         = 2'd1;
          end
          cur.valid = 1'b1;
          cur.lv    = cp_lv;
          cur.point = cp;
        end
        if (last) begin
          // flush the pending point as the end of the string
          res.pt[n]   = cur.point;
          res.last[n] = 1'b1;
          n           = n + 2'd1;
          held_upd    = '0;
        end else begin
          held_upd = cur;
        end
        res.cnt = n;
      end
      unf_pkg::MODE_NFD: begin
        if (in_hangul) begin
          res.pt[0] = unf_pkg::L_BASE + 21'(l_idx);
          res.pt[1] = unf_pkg::V_BASE + 21'(v_idx);
          res.pt[2] = unf_pkg::T_BASE + 21'(t_idx);
          if (t_idx == 5'd0) begin
            res.cnt     = 2'd2;
            res.last[1] = last;
          end else begin
            res.cnt     = 2'd3;
            res.last[2] = last;
          end
        end else if (dec.hit) begin
          res.pt[0]   = 21'(dec.letter);
          res.pt[1]   = 21'(dec.accent);
          res.last[1] = last;
          res.cnt     = 2'd2;
        end else begin
          res.pt[0]   = cp;
          res.last[0] = last;
          res.cnt     = 2'd1;
        end
      end
      default: begin
        res.pt[0]   = cp;
        res.last[0] = last;
        res.cnt     = 2'd1;
      end
    endcase
  end

endmodule

FILE: hw/rtl/unicode_normalizer_nfc_nfd.sv
// ----------------------------------------------------------------------------
// unicode_normalizer_nfc_nfd
// Simplified NFC / NFD normalizer over a stream of code points.
// ----------------------------------------------------------------------------
// Path: input register (in_cp_r), then result register (pt_r) to the output.
// Throughput: one item per cycle while each gives at most one result and the
//   output is ready; an item with k results (k up to 3) holds pt_r till all go.
// Reset: synchronous, active low; clears mode, pending point and both stages.
module unicode_normalizer_nfc_nfd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  unf_in_if.sink      in_ch,
  unf_out_if.source   out_ch
);

  logic                   in_valid_r;
  logic [20:0]            in_cp_r;
  logic                   in_last_r;
  logic [1:0]             mode_r;
  unf_pkg::held_t         held_r;
  unf_pkg::held_t         held_upd;
  unf_pkg::result_t       dec_res;
  logic [1:0]             cnt_r;
  logic [1:0]             idx_r;
  logic [2:0][20:0]       pt_r;
  logic [2:0]             last_r;
  logic                   out_fire;
  logic                   out_done;
  logic                   load;

  unf_decode u_decode (
    .mode     (mode_r),
    .cp       (in_cp_r),
    .last     (in_last_r),
    .held     (held_r),
    .res      (dec_res),
    .held_upd (held_upd)
  );

  assign out_fire = (cnt_r != 2'd0) && out_ch.ready;
  assign out_done = out_fire && (idx_r == cnt_r - 2'd1);
  assign load     = in_valid_r && ((cnt_r == 2'd0) || out_done);

  assign in_ch.ready      = !in_valid_r || load;
  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.out_point = pt_r[idx_r];
  assign out_ch.last_out  = last_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      mode_r     <= unf_pkg::MODE_PASS;
      held_r     <= '0;
      cnt_r      <= 2'd0;
      idx_r      <= 2'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (load) begin
        in_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
        held_r <= '0;   // drop any pending point
      end else if (load) begin
        held_r <= held_upd;
      end
      if (load) begin
        cnt_r <= dec_res.cnt;
        idx_r <= 2'd0;
      end else if (out_done) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else if (out_fire) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_cp_r   <= in_ch.code_point;
      in_last_r <= in_ch.last_in;
    end
    if (load) begin
      pt_r   <= dec_res.pt;
      last_r <= dec_res.last;
    end
  end

endmodule

FILE: hw/rtl/unf_checker.sv
// ----------------------------------------------------------------------------
// unf_checker
// Port-level checks on the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module unf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_point,
  input logic        out_last
);

  // input stalls only behind a result that is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("block not empty after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_point) && $stable(out_last)))
    else $error("result changed while stalled");

endmodule

bind unicode_normalizer_nfc_nfd unf_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_point (out_ch.out_point),
  .out_last  (out_ch.last_out)
);
